### hdl/wtjs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wtjs_pkg;

	localparam int PT_W        = 16;
	localparam int ETA_W       = 12;
	localparam int TAG_W       = 16;
	localparam int RANK_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PT_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PT_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ETA_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ETA_HIGH = 2'd3;

	localparam logic [PT_W-1:0]         PT_LOW_RST   = 16'h0000;
	localparam logic [PT_W-1:0]         PT_HIGH_RST  = 16'hFFFF;
	localparam logic signed [ETA_W-1:0] ETA_LOW_RST  = 12'sh800;
	localparam logic signed [ETA_W-1:0] ETA_HIGH_RST = 12'sh7FF;

	// One classified jet as it travels from the front to the back.
	typedef struct packed {
		logic                    pass;
		logic signed [TAG_W-1:0] tag;
		logic                    last;
	} jet_item_t;

endpackage
`default_nettype wire

### hdl/windowed_top4_jet_tag_select.sv
// Flow: a jet is registered in the front stage, then written to the queue; a jet marked last is
// popped into a single snapshot, which offers its results from rank 0. Throughput: one jet per
// cycle while in_ready is high; results leave one per cycle while out_ready is high, TOP_COUNT
// beats, so the next event's jets are taken meanwhile; its last jet waits for the snapshot.
// Reset: asynchronous, clears the cuts to their full windows, the queue and the list.
`timescale 1ns / 1ps
`default_nettype none
module windowed_top4_jet_tag_select #(
	parameter int TOP_COUNT = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [wtjs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wtjs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [wtjs_pkg::PT_W-1:0]              jet_pt,
	input  logic signed [wtjs_pkg::ETA_W-1:0]      jet_eta,
	input  logic signed [wtjs_pkg::TAG_W-1:0]      jet_tag,
	input  logic                                   last_jet,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [wtjs_pkg::RANK_W-1:0]            rank,
	output logic signed [wtjs_pkg::TAG_W-1:0]      tag_value,
	output logic                                   entry_valid,
	output logic                                   last_of_run
);

	localparam int CNT_W = $clog2(TOP_COUNT + 1);

	logic                         push;
	wtjs_pkg::jet_item_t          push_item;
	logic                         queue_full;
	logic                         queue_empty;
	logic                         pop;
	wtjs_pkg::jet_item_t          head_item;
	logic [wtjs_pkg::QCNT_W-1:0]  queue_fill;
	logic [CNT_W-1:0]             live_count;

	wtjs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.jet_pt     (jet_pt),
		.jet_eta    (jet_eta),
		.jet_tag    (jet_tag),
		.last_jet   (last_jet),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	wtjs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (head_item),
		.empty     (queue_empty),
		.fill      (queue_fill)
	);

	wtjs_back #(
		.TOP_COUNT (TOP_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rank        (rank),
		.tag_value   (tag_value),
		.entry_valid (entry_valid),
		.last_of_run (last_of_run),
		.live_count  (live_count)
	);

	a_live_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_count <= CNT_W'(TOP_COUNT))
		else $error("Running list holds more entries than it has places.");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(queue_fill <= wtjs_pkg::QCNT_W'(wtjs_pkg::QUEUE_DEPTH)) && !(push && queue_full))
		else $error("Queue overfilled.");

	a_empty_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> tag_value == '0)
		else $error("Unfilled rank carries a non-zero tag.");

	a_final_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> rank == wtjs_pkg::RANK_W'(TOP_COUNT - 1))
		else $error("Closing beat of an event is not the lowest rank.");

endmodule
`default_nettype wire

### hdl/wtjs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wtjs_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [wtjs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wtjs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [wtjs_pkg::PT_W-1:0]              jet_pt,
	input  logic signed [wtjs_pkg::ETA_W-1:0]      jet_eta,
	input  logic signed [wtjs_pkg::TAG_W-1:0]      jet_tag,
	input  logic                                   last_jet,
	output logic                                   push,
	output wtjs_pkg::jet_item_t                    push_item,
	input  logic                                   queue_full
);

	logic [wtjs_pkg::PT_W-1:0]         pt_low_q;
	logic [wtjs_pkg::PT_W-1:0]         pt_high_q;
	logic signed [wtjs_pkg::ETA_W-1:0] eta_low_q;
	logic signed [wtjs_pkg::ETA_W-1:0] eta_high_q;
	logic                              valid_s1;
	wtjs_pkg::jet_item_t               item_s1;
	logic                              pass;
	logic                              advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_low_q   <= wtjs_pkg::PT_LOW_RST;
			pt_high_q  <= wtjs_pkg::PT_HIGH_RST;
			eta_low_q  <= wtjs_pkg::ETA_LOW_RST;
			eta_high_q <= wtjs_pkg::ETA_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wtjs_pkg::CFG_PT_LOW:   pt_low_q   <= cfg_wdata;
				wtjs_pkg::CFG_PT_HIGH:  pt_high_q  <= cfg_wdata;
				wtjs_pkg::CFG_ETA_LOW:  eta_low_q  <= cfg_wdata[wtjs_pkg::ETA_W-1:0];
				wtjs_pkg::CFG_ETA_HIGH: eta_high_q <= cfg_wdata[wtjs_pkg::ETA_W-1:0];
				default: ;
			endcase
		end
	end

	assign pass = (jet_pt >= pt_low_q) && (jet_pt <= pt_high_q) &&
	              (jet_eta >= eta_low_q) && (jet_eta <= eta_high_q);

	assign advance  = !valid_s1 || !queue_full;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1.pass <= pass;
			item_s1.tag  <= jet_tag;
			item_s1.last <= last_jet;
		end
	end

	assign push      = valid_s1 && !queue_full;
	assign push_item = item_s1;

endmodule
`default_nettype wire

### hdl/wtjs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module wtjs_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  wtjs_pkg::jet_item_t               push_item,
	output logic                              full,
	input  logic                              pop,
	output wtjs_pkg::jet_item_t               pop_item,
	output logic                              empty,
	output logic [wtjs_pkg::QCNT_W-1:0]       fill
);

	wtjs_pkg::jet_item_t              slot_q [wtjs_pkg::QUEUE_DEPTH];
	logic [wtjs_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [wtjs_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [wtjs_pkg::QCNT_W-1:0]      count_q;

	assign full     = (count_q == wtjs_pkg::QCNT_W'(wtjs_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign fill     = count_q;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/wtjs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wtjs_back #(
	parameter int TOP_COUNT = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 queue_empty,
	input  wtjs_pkg::jet_item_t                  head_item,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [wtjs_pkg::RANK_W-1:0]          rank,
	output logic signed [wtjs_pkg::TAG_W-1:0]    tag_value,
	output logic                                 entry_valid,
	output logic                                 last_of_run,
	output logic [$clog2(TOP_COUNT+1)-1:0]       live_count
);

	localparam int CNT_W = $clog2(TOP_COUNT + 1);
	localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TOP_COUNT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TOP_COUNT - 1);

	logic signed [wtjs_pkg::TAG_W-1:0] live_q [TOP_COUNT];
	logic signed [wtjs_pkg::TAG_W-1:0] ins    [TOP_COUNT];
	logic signed [wtjs_pkg::TAG_W-1:0] snap_q [TOP_COUNT];
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  cnt_next;
	logic [CNT_W-1:0]                  snap_cnt_q;
	logic [TOP_COUNT-1:0]              ge;
	logic                              busy_q;
	logic [IDX_W-1:0]                  idx_q;
	logic                              out_fire;
	logic                              final_beat;
	logic                              snap_free;

	// Each kept entry at or above the new tag stays put; the tag drops in
	// just below them and the rest shift down by one place.
	always_comb begin
		for (int i = 0; i < TOP_COUNT; i++) begin
			ge[i] = (CNT_W'(i) < cnt_q) && (live_q[i] >= head_item.tag);
		end
		ins[0] = ge[0] ? live_q[0] : head_item.tag;
		for (int i = 1; i < TOP_COUNT; i++) begin
			if (ge[i]) begin
				ins[i] = live_q[i];
			end else if (ge[i-1]) begin
				ins[i] = head_item.tag;
			end else begin
				ins[i] = live_q[i-1];
			end
		end
	end

	assign cnt_next = (head_item.pass && (cnt_q < CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

	assign out_fire   = busy_q && out_ready;
	assign final_beat = out_fire && (idx_q == IDX_LAST);
	assign snap_free  = !busy_q || final_beat;
	assign pop        = !queue_empty && (!head_item.last || snap_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (out_fire) begin
				if (idx_q == IDX_LAST) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (pop) begin
				if (head_item.last) begin
					cnt_q  <= '0;
					busy_q <= 1'b1;
					idx_q  <= '0;
				end else begin
					cnt_q <= cnt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_item.last) begin
				snap_cnt_q <= cnt_next;
				for (int i = 0; i < TOP_COUNT; i++) begin
					snap_q[i] <= head_item.pass ? ins[i] : live_q[i];
				end
			end else if (head_item.pass) begin
				for (int i = 0; i < TOP_COUNT; i++) begin
					live_q[i] <= ins[i];
				end
			end
		end
	end

	assign out_valid   = busy_q;
	assign rank        = wtjs_pkg::RANK_W'(idx_q);
	assign entry_valid = (CNT_W'(idx_q) < snap_cnt_q);
	assign tag_value   = entry_valid ? snap_q[idx_q] : '0;
	assign last_of_run = (idx_q == IDX_LAST);
	assign live_count  = cnt_q;

endmodule
`default_nettype wire

### tb/windowed_top4_jet_tag_select_tb.sv
`timescale 1ns / 1ps
module windowed_top4_jet_tag_select_tb;
	import wtjs_pkg::*;

	localparam int DIR_ROWS = 24;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_JETS = 26;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	// Far above the longest quiet spell of a correct run, the receiver hold included.
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [RANK_W-1:0]       rank;
		logic signed [TAG_W-1:0] tag;
		logic                    ok;
		logic                    fin;
	} tag_rank_t;

	typedef struct packed {
		logic [PT_W-1:0]         pt_lo;
		logic [PT_W-1:0]         pt_hi;
		logic signed [ETA_W-1:0] eta_lo;
		logic signed [ETA_W-1:0] eta_hi;
	} cut_set_t;

	// A row with typed set carries its own result: one kept tag t0, or none.
	typedef struct packed {
		logic [1:0]              cut_set;
		logic [PT_W-1:0]         pt;
		logic signed [ETA_W-1:0] eta;
		logic signed [TAG_W-1:0] tag;
		logic                    last;
		logic                    typed;
		logic                    one_kept;
		logic signed [TAG_W-1:0] t0;
	} jet_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PT_LOW;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PT_W-1:0] jet_pt = '0;
	logic signed [ETA_W-1:0] jet_eta = '0;
	logic signed [TAG_W-1:0] jet_tag = '0;
	logic last_jet = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [RANK_W-1:0] rank;
	logic signed [TAG_W-1:0] tag_value;
	logic entry_valid;
	logic last_of_run;

	tag_rank_t expected_ranks [$];
	logic [PT_W-1:0] cut_pt_lo = PT_LOW_RST;
	logic [PT_W-1:0] cut_pt_hi = PT_HIGH_RST;
	logic signed [ETA_W-1:0] cut_eta_lo = ETA_LOW_RST;
	logic signed [ETA_W-1:0] cut_eta_hi = ETA_HIGH_RST;
	logic signed [TAG_W-1:0] top_tags [4] = '{default: '0};
	int n_kept = 0;

	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;

	cut_set_t dir_cuts [4] = '{
		'{PT_LOW_RST, PT_HIGH_RST, ETA_LOW_RST, ETA_HIGH_RST},
		'{16'd100, 16'd200, -12'sd50, 12'sd60},
		'{16'd300, 16'd299, ETA_LOW_RST, ETA_HIGH_RST},
		'{PT_LOW_RST, PT_HIGH_RST, 12'sd10, 12'sd9}
	};

	jet_row_t dir_rows [DIR_ROWS] = '{
		'{2'd0, 16'd0, 12'sh800, 16'sh8000, 1'b1, 1'b1, 1'b1, 16'sh8000},
		'{2'd0, 16'hFFFF, 12'sh7FF, 16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh7FFF},
		'{2'd0, 16'd1234, 12'sd0, 16'sd0, 1'b1, 1'b1, 1'b1, 16'sd0},
		'{2'd0, 16'd10, 12'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd20, -12'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd30, 12'sd7, -16'sd3, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd40, 12'sd8, 16'sd100, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd50, 12'sd9, 16'sd5, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd60, 12'sd10, 16'sd7, 1'b1, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd70, 12'sd1, -16'sd1, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd71, 12'sd2, -16'sd1, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd72, 12'sd3, -16'sd1, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd0, 16'd73, 12'sd4, -16'sd1, 1'b1, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd99, 12'sd0, 16'sd11, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd100, 12'sd0, 16'sd22, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd200, 12'sd60, 16'sd33, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd201, 12'sd0, 16'sd44, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd150, -12'sd51, 16'sd55, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd150, -12'sd50, 16'sd66, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd1, 16'd150, 12'sd61, 16'sd77, 1'b1, 1'b0, 1'b0, 16'sd0},
		'{2'd2, 16'd300, 12'sd0, 16'sd5, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd2, 16'd299, 12'sd0, 16'sd6, 1'b1, 1'b1, 1'b0, 16'sd0},
		'{2'd3, 16'd10, 12'sd10, 16'sd7, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{2'd3, 16'd10, 12'sd9, 16'sd8, 1'b1, 1'b1, 1'b0, 16'sd0}
	};

	windowed_top4_jet_tag_select u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.jet_pt(jet_pt),
		.jet_eta(jet_eta),
		.jet_tag(jet_tag),
		.last_jet(last_jet),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rank(rank),
		.tag_value(tag_value),
		.entry_valid(entry_valid),
		.last_of_run(last_of_run)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Applies the cut windows, keeps the four largest tags and, on the last jet of an
	// event, queues the four ranked results and clears the list.
	function automatic void rank_jet(input logic [PT_W-1:0] pt, input logic signed [ETA_W-1:0] eta,
			input logic signed [TAG_W-1:0] tag, input logic last, input logic typed,
			input logic one_kept, input logic signed [TAG_W-1:0] t0);
		int pos;
		int i;
		tag_rank_t r;
		if (pt >= cut_pt_lo && pt <= cut_pt_hi && eta >= cut_eta_lo && eta <= cut_eta_hi) begin
			pos = 0;
			while (pos < n_kept && top_tags[pos] >= tag)
				pos++;
			if (pos < 4) begin
				for (i = (n_kept < 4) ? n_kept : 3; i > pos; i--)
					top_tags[i] = top_tags[i - 1];
				top_tags[pos] = tag;
				if (n_kept < 4)
					n_kept++;
			end
		end
		if (last) begin
			for (i = 0; i < 4; i++) begin
				r.rank = RANK_W'(i);
				r.fin = (i == 3);
				if (typed) begin
					r.ok = (i == 0) && one_kept;
					r.tag = r.ok ? t0 : '0;
				end else begin
					r.ok = (i < n_kept);
					r.tag = r.ok ? top_tags[i] : '0;
				end
				expected_ranks.insert(expected_ranks.size(), r);
			end
			top_tags = '{default: '0};
			n_kept = 0;
		end
	endfunction

	task automatic send_jet(input logic [PT_W-1:0] pt, input logic signed [ETA_W-1:0] eta,
			input logic signed [TAG_W-1:0] tag, input logic last, input logic typed,
			input logic one_kept, input logic signed [TAG_W-1:0] t0);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		jet_pt <= pt;
		jet_eta <= eta;
		jet_tag <= tag;
		last_jet <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rank_jet(pt, eta, tag, last, typed, one_kept, t0);
	endtask

	task automatic hold_until_drained(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_ranks.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic put_cut(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		case (idx)
			CFG_PT_LOW: cut_pt_lo = d;
			CFG_PT_HIGH: cut_pt_hi = d;
			CFG_ETA_LOW: cut_eta_lo = d[ETA_W-1:0];
			CFG_ETA_HIGH: cut_eta_hi = d[ETA_W-1:0];
		endcase
	endtask

	// The bits above the eta field carry noise, which the block must ignore.
	task automatic write_cuts(input cut_set_t cs);
		put_cut(CFG_PT_LOW, cs.pt_lo);
		put_cut(CFG_PT_HIGH, cs.pt_hi);
		put_cut(CFG_ETA_LOW, {4'($urandom), cs.eta_lo});
		put_cut(CFG_ETA_HIGH, {4'($urandom), cs.eta_hi});
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		tag_rank_t want;
		if (out_valid && out_ready) begin
			if (expected_ranks.size() == 0) begin
				report_mismatch($sformatf("unexpected beat rank %0d tag %0d", rank, tag_value));
			end else begin
				want = expected_ranks.pop_front();
				if (rank !== want.rank)
					report_mismatch($sformatf("rank %0d, want %0d", rank, want.rank));
				if (tag_value !== want.tag)
					report_mismatch($sformatf("rank %0d tag_value %0d, want %0d",
						want.rank, tag_value, want.tag));
				if (entry_valid !== want.ok)
					report_mismatch($sformatf("rank %0d entry_valid %b, want %b",
						want.rank, entry_valid, want.ok));
				if (last_of_run !== want.fin)
					report_mismatch($sformatf("rank %0d last_of_run %b, want %b",
						want.rank, last_of_run, want.fin));
			end
		end
	end

	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("windowed_top4_jet_tag_select_tb: errors");
			$finish;
		end
	end

	initial begin
		int ph;
		int n;
		int len;
		int j;
		logic [PT_W-1:0] a16;
		logic [PT_W-1:0] b16;
		logic signed [ETA_W-1:0] ea;
		logic signed [ETA_W-1:0] eb;
		logic [1:0] cur_set;
		logic paused;
		cut_set_t cs;
		logic [PT_W-1:0] pt;
		logic signed [ETA_W-1:0] eta;
		logic signed [TAG_W-1:0] tag;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run on the cut windows left by reset.
		tx_idle_pct = 25;
		rx_stall_pct = 25;
		cur_set = 2'd0;
		for (j = 0; j < DIR_ROWS; j++) begin
			if (dir_rows[j].cut_set != cur_set) begin
				cur_set = dir_rows[j].cut_set;
				hold_until_drained(SETTLE_CYCLES);
				write_cuts(dir_cuts[cur_set]);
			end
			send_jet(dir_rows[j].pt, dir_rows[j].eta, dir_rows[j].tag, dir_rows[j].last,
				dir_rows[j].typed, dir_rows[j].one_kept, dir_rows[j].t0);
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			hold_until_drained(SETTLE_CYCLES);
			case (ph % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 72; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 72; end
				default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
			endcase
			a16 = PT_W'($urandom);
			b16 = PT_W'($urandom);
			ea = ETA_W'($urandom);
			eb = ETA_W'($urandom);
			case (ph)
				0: cs = '{16'h0000, 16'hFFFF, 12'sh800, 12'sh7FF};
				1: cs = '{16'hFFFF, 16'hFFFF, 12'sh7FF, 12'sh7FF};
				2: cs = '{16'h0000, 16'h0000, 12'sh800, 12'sh800};
				default: cs = '{(a16 < b16) ? a16 : b16, (a16 < b16) ? b16 : a16,
					(ea < eb) ? ea : eb, (ea < eb) ? eb : ea};
			endcase
			write_cuts(cs);
			if (ph == 4)
				rx_hold_req = 1'b1;
			paused = 1'b0;
			n = 0;
			while (n < PHASE_JETS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(6, 1);
				for (j = 0; j < len; j++) begin
					if ($urandom_range(99) < 80) begin
						pt = PT_W'($urandom_range(int'(cut_pt_hi), int'(cut_pt_lo)));
						eta = ETA_W'(int'(cut_eta_lo)
							+ $urandom_range(int'(cut_eta_hi) - int'(cut_eta_lo)));
						if ($urandom_range(9) == 0)
							pt = $urandom_range(1) ? cut_pt_lo : cut_pt_hi;
						if ($urandom_range(9) == 0)
							eta = $urandom_range(1) ? cut_eta_lo : cut_eta_hi;
					end else begin
						pt = PT_W'($urandom);
						eta = ETA_W'($urandom);
					end
					if ($urandom_range(99) < 30)
						tag = TAG_W'($urandom_range(4)) - 16'sd2;
					else
						tag = TAG_W'($urandom);
					send_jet(pt, eta, tag, j == len - 1, 1'b0, 1'b0, '0);
					n++;
				end
				if (ph == 6 && !paused && n >= PHASE_JETS / 2) begin
					paused = 1'b1;
					hold_until_drained(0);
				end
			end
		end

		hold_until_drained(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("windowed_top4_jet_tag_select_tb: clean");
		else
			$display("windowed_top4_jet_tag_select_tb: errors");
		$finish;
	end

endmodule

### windowed_top4_jet_tag_select.f
hdl/wtjs_pkg.sv
hdl/wtjs_front.sv
hdl/wtjs_queue.sv
hdl/wtjs_back.sv
hdl/windowed_top4_jet_tag_select.sv
tb/windowed_top4_jet_tag_select_tb.sv
